>>> sv/lsd_pkg.sv
// shared types, codes and saturation helpers for the linear svm decision block
`default_nettype none
package lsd_pkg;

  localparam logic [2:0] OP_LOAD_SHIFT = 3'd0;
  localparam logic [2:0] OP_LOAD_SCALE = 3'd1;
  localparam logic [2:0] OP_LOAD_SV    = 3'd2;
  localparam logic [2:0] OP_LOAD_ALPHA = 3'd3;
  localparam logic [2:0] OP_CLASSIFY   = 3'd4;

  localparam logic [1:0] CFG_SV_COUNT  = 2'd0;
  localparam logic [1:0] CFG_DIM_COUNT = 2'd1;
  localparam logic [1:0] CFG_BIAS      = 2'd2;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [7:0]         sv_index;
    logic [1:0]         dim_index;
    logic signed [31:0] load_value;
    logic signed [31:0] feature_0;
    logic signed [31:0] feature_1;
    logic signed [31:0] feature_2;
    logic signed [31:0] feature_3;
  } in_item_t;

  typedef struct packed {
    logic               decision;
    logic signed [47:0] score;
  } out_item_t;

  typedef enum logic [2:0] {
    KIND_SHIFT,
    KIND_SCALE,
    KIND_SV,
    KIND_ALPHA,
    KIND_CLASSIFY
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         sv_index;
    logic [1:0]         dim_index;
    logic signed [31:0] load_value;
    logic signed [31:0] feature_0;
    logic signed [31:0] feature_1;
    logic signed [31:0] feature_2;
    logic signed [31:0] feature_3;
  } cmd_t;

  typedef struct packed {
    logic [8:0]         sv_count;
    logic [2:0]         dim_count;
    logic signed [31:0] bias;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic pipe_active;
  } eng_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
    logic hi_same;
    hi_same = (&v[79:31]) | ~(|v[79:31]);
    if (hi_same) return v[31:0];
    else if (v[79]) return 32'sh8000_0000;
    else return 32'sh7fff_ffff;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [79:0] v);
    logic hi_same;
    hi_same = (&v[79:47]) | ~(|v[79:47]);
    if (hi_same) return v[47:0];
    else if (v[79]) return 48'sh8000_0000_0000;
    else return 48'sh7fff_ffff_ffff;
  endfunction

endpackage
`default_nettype wire

>>> sv/linear_svm_decision.sv
// top level of the linear-kernel svm decision block
// usage
//   input channel (in_valid / in_stall / in_data) carries one request each:
//   a table load (shift, scale, support-vector element, alpha) or a classify
//   result channel (out_valid / out_stall / out_data) gives one score and
//   decision bit per classify; loads and unknown opcodes give nothing
//   configuration port (cfg_we / cfg_index / cfg_wdata) writes sv_count,
//   dim_count and bias; the user writes only while idle, unenforced by the block
// flow
//   a two-entry queue sits between the decoder and the engine; a request waits
//   there for the idle engine, a load is written to its table as it is popped;
//   a classify holds the engine while S_PRE1 to S_PRE3 shift and scale the
//   features, S_WALK (skipped if nsv is zero) visits each support vector, S_DRAIN
//   empties the pipeline and S_OUT registers the result (nsv = min(sv_count, MAX_SV))
// reset and stall
//   rst_n (synchronous) clears the queue, the engine and the output valid;
//   registers return to sv_count 0, dim_count 2, bias 0, tables are unknown
//   a stalled result holds in the output register while the next request
//   is already being worked on, up to the point of delivering its result
`default_nettype none
module linear_svm_decision #(
  parameter int MAX_SV    = 256,
  parameter int MAX_DIM   = 4,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lsd_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lsd_pkg::out_item_t       out_data,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_wdata
);

  // configuration registers
  lsd_pkg::cfg_t      cfg_r;
  lsd_pkg::cmd_t      q_data;
  logic               q_valid;
  logic               q_pop;
  lsd_pkg::eng_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sv_count  <= 9'd0;
      cfg_r.dim_count <= 3'd2;
      cfg_r.bias      <= 32'sd0;
    end else if (cfg_we) begin
      case (cfg_index)
        lsd_pkg::CFG_SV_COUNT:  cfg_r.sv_count  <= cfg_wdata[8:0];
        lsd_pkg::CFG_DIM_COUNT: cfg_r.dim_count <= cfg_wdata[2:0];
        lsd_pkg::CFG_BIAS:      cfg_r.bias      <= cfg_wdata;
        default: ; // unknown index ignored
      endcase
    end
  end

  // decode and queue requests
  lsd_front #(.MAX_SV(MAX_SV), .MAX_DIM(MAX_DIM)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  // loads, scaling, vector walk and the output register
  lsd_engine #(.MAX_SV(MAX_SV), .MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .stat      (stat)
  );

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("engine popped an empty queue");

  a_pipe_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    stat.pipe_active |-> stat.busy)
    else $error("walk pipeline active while engine idle");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(stat.busy))
    else $error("result appeared without a classify in progress");
`endif

endmodule
`default_nettype wire

>>> sv/lsd_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module lsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/lsd_front.sv
// front end: takes requests, decodes them and queues them for the engine
`default_nettype none
module lsd_front #(
  parameter int MAX_SV  = 256,
  parameter int MAX_DIM = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire lsd_pkg::in_item_t in_data,
  output logic                  q_valid,
  output lsd_pkg::cmd_t         q_data,
  input  wire logic             q_pop
);

  lsd_pkg::cmd_t ent_r [2];
  logic          wptr_r;
  logic          rptr_r;
  logic [1:0]    cnt_r;
  logic          keep;
  logic          push;
  logic          dim_ok;
  logic          sv_ok;
  lsd_pkg::cmd_t cmd;

  assign dim_ok = 32'(in_data.dim_index) < MAX_DIM;
  assign sv_ok  = 32'(in_data.sv_index) < MAX_SV;

  always_comb begin
    cmd.kind       = lsd_pkg::KIND_CLASSIFY;
    cmd.sv_index   = in_data.sv_index;
    cmd.dim_index  = in_data.dim_index;
    cmd.load_value = in_data.load_value;
    cmd.feature_0  = in_data.feature_0;
    cmd.feature_1  = in_data.feature_1;
    cmd.feature_2  = in_data.feature_2;
    cmd.feature_3  = in_data.feature_3;
    keep           = 1'b0;
    case (in_data.opcode)
      lsd_pkg::OP_LOAD_SHIFT: begin
        cmd.kind = lsd_pkg::KIND_SHIFT;
        keep     = dim_ok;
      end
      lsd_pkg::OP_LOAD_SCALE: begin
        cmd.kind = lsd_pkg::KIND_SCALE;
        keep     = dim_ok;
      end
      lsd_pkg::OP_LOAD_SV: begin
        cmd.kind = lsd_pkg::KIND_SV;
        keep     = dim_ok && sv_ok;
      end
      lsd_pkg::OP_LOAD_ALPHA: begin
        cmd.kind = lsd_pkg::KIND_ALPHA;
        keep     = sv_ok;
      end
      lsd_pkg::OP_CLASSIFY: begin
        cmd.kind = lsd_pkg::KIND_CLASSIFY;
        keep     = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = ent_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (q_pop) rptr_r <= ~rptr_r;
      case ({push, q_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/lsd_engine.sv
// back end: table loads, feature scaling and the support-vector walk
`default_nettype none
module lsd_engine #(
  parameter int MAX_SV    = 256,
  parameter int MAX_DIM   = 4,
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire lsd_pkg::cmd_t      q_data,
  output logic                    q_pop,
  input  wire lsd_pkg::cfg_t      cfg,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output lsd_pkg::out_item_t      out_data,
  output lsd_pkg::eng_stat_t      stat
);

  localparam int AW = (MAX_SV > 1) ? $clog2(MAX_SV) : 1;
  localparam int CW = $clog2(MAX_SV + 1) > 0 ? $clog2(MAX_SV + 1) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_PRE1, S_PRE2, S_PRE3, S_WALK, S_DRAIN, S_OUT
  } state_t;

  state_t             state_r;
  logic [CW-1:0]      k_r;
  logic [CW-1:0]      nsv;
  logic               v0_r, v1_r, v2_r, v3_r;
  logic               out_valid_r;
  lsd_pkg::out_item_t out_data_r;
  lsd_pkg::cmd_t      cmd_r;

  logic signed [31:0] shift_r   [MAX_DIM];
  logic signed [31:0] scale_r   [MAX_DIM];
  logic signed [31:0] feat      [MAX_DIM];
  logic signed [31:0] shifted_r [MAX_DIM];
  logic signed [63:0] mul_r     [MAX_DIM];
  logic signed [31:0] scaled_r  [MAX_DIM];
  logic signed [63:0] prod_r    [MAX_DIM];
  logic        [31:0] sv_rd     [MAX_DIM];
  logic        [MAX_DIM-1:0] lane_en;

  logic        [31:0] alpha_rd;
  logic signed [31:0] alpha1_r, alpha2_r;
  logic signed [31:0] dot_r;
  logic signed [63:0] tp_r;
  logic signed [47:0] acc_r;
  logic signed [79:0] dsum;
  logic signed [47:0] score_w;
  logic               last_k;

  assign nsv    = (32'(cfg.sv_count) > MAX_SV) ? CW'(MAX_SV) : CW'(cfg.sv_count);
  assign last_k = (CW'(k_r + 1'b1) == nsv);
  assign q_pop  = (state_r == S_IDLE) && q_valid;

  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;
  assign stat.busy        = (state_r != S_IDLE);
  assign stat.pipe_active = v0_r | v1_r | v2_r | v3_r;

  // one lane per dimension
  for (genvar d = 0; d < MAX_DIM; d++) begin : g_lane
    if (d == 0) begin : g_f0
      assign feat[d] = cmd_r.feature_0;
    end else if (d == 1) begin : g_f1
      assign feat[d] = cmd_r.feature_1;
    end else if (d == 2) begin : g_f2
      assign feat[d] = cmd_r.feature_2;
    end else if (d == 3) begin : g_f3
      assign feat[d] = cmd_r.feature_3;
    end else begin : g_fz
      assign feat[d] = 32'sd0;
    end

    assign lane_en[d] = 32'(cfg.dim_count) > d;

    lsd_ram #(.WIDTH(32), .DEPTH(MAX_SV)) u_sv_ram (
      .clk   (clk),
      .we    (q_pop && q_data.kind == lsd_pkg::KIND_SV && 32'(q_data.dim_index) == d),
      .waddr (AW'(q_data.sv_index)),
      .wdata (q_data.load_value),
      .raddr (k_r[AW-1:0]),
      .rdata (sv_rd[d])
    );

    always_ff @(posedge clk) begin
      if (q_pop && q_data.kind == lsd_pkg::KIND_SHIFT && 32'(q_data.dim_index) == d) begin
        shift_r[d] <= q_data.load_value;
      end
      if (q_pop && q_data.kind == lsd_pkg::KIND_SCALE && 32'(q_data.dim_index) == d) begin
        scale_r[d] <= q_data.load_value;
      end
      if (state_r == S_PRE1) begin
        shifted_r[d] <= lsd_pkg::sat32(80'(feat[d]) + 80'(shift_r[d]));
      end
      if (state_r == S_PRE2) begin
        mul_r[d] <= shifted_r[d] * scale_r[d];
      end
      if (state_r == S_PRE3) begin
        scaled_r[d] <= lane_en[d] ? lsd_pkg::sat32(80'(mul_r[d] >>> FRAC_BITS)) : 32'sd0;
      end
      // lanes beyond dim_count add nothing, whatever their table holds
      prod_r[d] <= lane_en[d] ? $signed(sv_rd[d]) * scaled_r[d] : 64'sd0;
    end
  end

  lsd_ram #(.WIDTH(32), .DEPTH(MAX_SV)) u_alpha_ram (
    .clk   (clk),
    .we    (q_pop && q_data.kind == lsd_pkg::KIND_ALPHA),
    .waddr (AW'(q_data.sv_index)),
    .wdata (q_data.load_value),
    .raddr (k_r[AW-1:0]),
    .rdata (alpha_rd)
  );

  always_comb begin
    dsum = 80'sd0;
    for (int d = 0; d < MAX_DIM; d++) begin
      dsum = dsum + 80'(prod_r[d] >>> FRAC_BITS);
    end
  end

  assign score_w = lsd_pkg::sat48(80'(acc_r) + 80'(cfg.bias));

  // walk datapath: product, dot, alpha product, accumulate
  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= q_data;
    alpha1_r <= $signed(alpha_rd);
    alpha2_r <= alpha1_r;
    dot_r    <= lsd_pkg::sat32(dsum);
    tp_r     <= dot_r * alpha2_r;
    if (state_r == S_PRE3) begin
      acc_r <= 48'sd0;
    end else if (v3_r) begin
      acc_r <= lsd_pkg::sat48(80'(acc_r) + 80'(tp_r >>> FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v0_r <= (state_r == S_WALK);
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid && q_data.kind == lsd_pkg::KIND_CLASSIFY) state_r <= S_PRE1;
        end
        S_PRE1: state_r <= S_PRE2;
        S_PRE2: state_r <= S_PRE3;
        S_PRE3: begin
          k_r     <= '0;
          state_r <= (nsv == '0) ? S_DRAIN : S_WALK;
        end
        S_WALK: begin
          k_r <= CW'(k_r + 1'b1);
          if (last_k) state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!(v0_r | v1_r | v2_r | v3_r)) state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r.score    <= score_w;
            out_data_r.decision <= score_w[47];
            state_r             <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_lsd_checker.sv
// checker for the linear svm decision block: predicts scores and compares results
module tb_lsd_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  lsd_pkg::in_item_t     in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  lsd_pkg::out_item_t    out_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_wdata,
  output int                    fail_count,
  output int                    pending_scores,
  output int                    scores_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;
  localparam longint S48_HI = 64'sd140737488355327;
  localparam longint S48_LO = -64'sd140737488355328;

  logic [8:0]  sv_count_q;
  logic [2:0]  dim_count_q;
  longint      bias_q;
  longint      shift_w [4];
  longint      scale_w [4];
  longint      vec_w [1024];
  longint      alpha_w [256];
  lsd_pkg::out_item_t score_queue [$];

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic lsd_pkg::out_item_t predict_score(lsd_pkg::in_item_t r);
    longint scaled [4];
    longint feat [4];
    longint acc, dot, s;
    int nsv, nd;
    lsd_pkg::out_item_t o;
    feat[0] = r.feature_0; feat[1] = r.feature_1;
    feat[2] = r.feature_2; feat[3] = r.feature_3;
    nsv = (sv_count_q > 256) ? 256 : sv_count_q;
    nd = (dim_count_q > 4) ? 4 : dim_count_q;
    acc = 0;
    for (int d = 0; d < nd; d++) begin
      s = clip(feat[d] + shift_w[d], S32_LO, S32_HI);
      scaled[d] = clip((s * scale_w[d]) >>> 16, S32_LO, S32_HI);
    end
    for (int k = 0; k < nsv; k++) begin
      dot = 0;
      for (int d = 0; d < nd; d++) dot += (vec_w[k*4+d] * scaled[d]) >>> 16;
      dot = clip(dot, S32_LO, S32_HI);
      acc = clip(acc + ((dot * alpha_w[k]) >>> 16), S48_LO, S48_HI);
    end
    acc = clip(acc + bias_q, S48_LO, S48_HI);
    o.decision = (acc < 0);
    o.score = acc[47:0];
    return o;
  endfunction

  always @(posedge clk) begin
    lsd_pkg::out_item_t e;
    int errs;
    errs = 0;
    if (!rst_n) begin
      sv_count_q <= 9'd0; dim_count_q <= 3'd2; bias_q = 0;
      fail_count <= 0; scores_seen <= 0;
      score_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lsd_pkg::CFG_SV_COUNT:  sv_count_q <= cfg_wdata[8:0];
          lsd_pkg::CFG_DIM_COUNT: dim_count_q <= cfg_wdata[2:0];
          lsd_pkg::CFG_BIAS:      bias_q = longint'(signed'(cfg_wdata));
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (in_data.opcode)
          lsd_pkg::OP_LOAD_SHIFT: shift_w[in_data.dim_index] = in_data.load_value;
          lsd_pkg::OP_LOAD_SCALE: scale_w[in_data.dim_index] = in_data.load_value;
          lsd_pkg::OP_LOAD_SV:
            vec_w[{in_data.sv_index, in_data.dim_index}] = in_data.load_value;
          lsd_pkg::OP_LOAD_ALPHA: alpha_w[in_data.sv_index] = in_data.load_value;
          lsd_pkg::OP_CLASSIFY: score_queue = {score_queue, predict_score(in_data)};
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        scores_seen <= scores_seen + 1;
        if (score_queue.size() == 0) begin
          $error("unexpected result: decision %0b score %0d", out_data.decision,
                 out_data.score);
          errs++;
        end else begin
          e = score_queue.pop_front();
          if (e.decision !== out_data.decision) begin
            $error("decision: expected %0b actual %0b", e.decision, out_data.decision);
            errs++;
          end
          if (e.score !== out_data.score) begin
            $error("score: expected %0d actual %0d", e.score, out_data.score);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    pending_scores <= score_queue.size();
  end
endmodule

>>> tb/tb_top.sv
// stimulus, clock and verdict for the linear svm decision testbench
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  lsd_pkg::in_item_t in_data = '0;
  lsd_pkg::out_item_t out_data;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  int fail_count, pending_scores, scores_seen;
  int cycle_count = 0;
  bit long_hold = 0;      // receiver holds off for a long stretch
  bit hold_done = 0;
  int classify_sent = 0;

  localparam int CYCLE_LIMIT = 2000000;

  linear_svm_decision dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_wdata
  );

  tb_lsd_checker checker_i (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_wdata, .fail_count, .pending_scores,
    .scores_seen
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // mostly short gaps, occasionally a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver side: random stall, one long hold-off counted here
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold && !hold_done) begin
        out_stall <= 1;
        repeat (3000) @(posedge clk);
        hold_done = 1;
      end
      n = gap_len();
      out_stall <= (n != 0) && ($urandom_range(0, 3) != 0);
      repeat (n + 1) @(posedge clk);
    end
  end

  // one request, held until taken
  task automatic send_request(lsd_pkg::in_item_t r, bit allow_gap = 1);
    int g;
    g = allow_gap ? gap_len() : 0;
    if (g) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (r.opcode == lsd_pkg::OP_CLASSIFY) classify_sent++;
  endtask

  task automatic go_quiet();
    in_valid <= 0;
    @(posedge clk);
    while (pending_scores != 0) @(posedge clk);
    // a trailing load may still be inside the engine
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
      default: return $urandom;
    endcase
  endfunction

  function automatic lsd_pkg::in_item_t make_load(logic [2:0] op, int k, int d,
                                                  logic [31:0] v);
    lsd_pkg::in_item_t r;
    r = '0;
    r.opcode = op;
    r.sv_index = 8'(k);
    r.dim_index = 2'(d);
    r.load_value = v;
    return r;
  endfunction

  function automatic lsd_pkg::in_item_t make_classify(bit wide);
    lsd_pkg::in_item_t r;
    r = '0;
    r.opcode = lsd_pkg::OP_CLASSIFY;
    r.sv_index = 8'($urandom);
    r.dim_index = 2'($urandom);
    r.load_value = $urandom;
    r.feature_0 = wide ? rand_word() : $urandom_range(0, 32'h8_0000) - 32'h4_0000;
    r.feature_1 = wide ? rand_word() : $urandom_range(0, 32'h8_0000) - 32'h4_0000;
    r.feature_2 = wide ? rand_word() : $urandom_range(0, 32'h8_0000) - 32'h4_0000;
    r.feature_3 = wide ? rand_word() : $urandom_range(0, 32'h8_0000) - 32'h4_0000;
    return r;
  endfunction

  // fill shift and scale for all dimensions, vectors and alphas for nsv entries
  task automatic fill_tables(int nsv, bit wide);
    for (int d = 0; d < 4; d++) begin
      send_request(make_load(lsd_pkg::OP_LOAD_SHIFT, $urandom, d,
                             wide ? rand_word() : $urandom_range(0, 32'h2_0000) - 32'h1_0000));
      send_request(make_load(lsd_pkg::OP_LOAD_SCALE, $urandom, d,
                             wide ? rand_word() : $urandom_range(0, 32'h2_0000) - 32'h1_0000));
    end
    for (int k = 0; k < nsv; k++) begin
      for (int d = 0; d < 4; d++)
        send_request(make_load(lsd_pkg::OP_LOAD_SV, k, d,
                               wide ? rand_word() : $urandom_range(0, 32'h2_0000) - 32'h1_0000));
      send_request(make_load(lsd_pkg::OP_LOAD_ALPHA, k, $urandom,
                             wide ? rand_word() : $urandom_range(0, 32'h2_0000) - 32'h1_0000));
    end
  endtask

  initial begin
    int nsv;
    int loaded_sv;
    lsd_pkg::in_item_t r;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset config with zero vectors gives bias alone
    loaded_sv = 4;
    fill_tables(4, 1);
    send_request(make_classify(1));
    go_quiet();
    write_reg(lsd_pkg::CFG_BIAS, 32'h8000_0000);
    send_request(make_classify(1));
    go_quiet();
    write_reg(lsd_pkg::CFG_BIAS, 32'h7fff_ffff);
    write_reg(lsd_pkg::CFG_SV_COUNT, 4);
    write_reg(lsd_pkg::CFG_DIM_COUNT, 4);
    r = make_classify(1);
    r.feature_0 = 32'h7fff_ffff; r.feature_1 = 32'h8000_0000;
    r.feature_2 = 32'hffff_ffff; r.feature_3 = 32'h0;
    send_request(r);
    send_request(make_load(3'd5, 0, 0, 0));   // unknown opcodes ignored
    send_request(make_load(3'd7, 255, 3, 32'hffff_ffff));
    send_request(make_classify(1));
    go_quiet();
    write_reg(lsd_pkg::CFG_DIM_COUNT, 0);     // zero dimensions
    write_reg(lsd_pkg::CFG_BIAS, 32'hffff_0000);
    send_request(make_classify(1));
    go_quiet();
    write_reg(lsd_pkg::CFG_DIM_COUNT, 7);     // clamps to four
    write_reg(lsd_pkg::CFG_SV_COUNT, 3);
    send_request(make_classify(1));
    go_quiet();
    write_reg(2'd3, 32'h1234_5678);           // unknown register index ignored

    // larger table with narrow values
    fill_tables(40, 0);
    loaded_sv = 40;
    go_quiet();
    write_reg(lsd_pkg::CFG_SV_COUNT, loaded_sv);
    write_reg(lsd_pkg::CFG_DIM_COUNT, 4);
    send_request(make_classify(0));
    send_request(make_classify(1));
    go_quiet();

    // long receiver hold-off while requests keep coming
    long_hold = 1;
    for (int i = 0; i < 8; i++) send_request(make_classify(0), 0);
    go_quiet();

    // random phases, mostly small vector counts
    for (int ph = 0; ph < 8; ph++) begin
      go_quiet();
      nsv = (ph % 4 == 3) ? $urandom_range(0, loaded_sv) : $urandom_range(0, 8);
      write_reg(lsd_pkg::CFG_SV_COUNT, nsv);
      write_reg(lsd_pkg::CFG_DIM_COUNT, $urandom_range(0, 7));
      write_reg(lsd_pkg::CFG_BIAS, rand_word());
      for (int i = 0; i < 18; i++) begin
        case ($urandom_range(0, 9))
          0: send_request(make_load(lsd_pkg::OP_LOAD_SHIFT, $urandom, $urandom, rand_word()));
          1: send_request(make_load(lsd_pkg::OP_LOAD_SCALE, $urandom, $urandom, rand_word()));
          2: send_request(make_load(lsd_pkg::OP_LOAD_SV, $urandom, $urandom, rand_word()));
          3: send_request(make_load(lsd_pkg::OP_LOAD_ALPHA, $urandom, $urandom, rand_word()));
          4: send_request(make_load(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom));
          default: send_request(make_classify($urandom_range(0, 1)));
        endcase
      end
    end
    go_quiet();

    $display("classify requests sent: %0d, results checked: %0d", classify_sent,
             scores_seen);
    $display("covered table loads, vector counts 0..40, dims 0..7, bias extremes, long hold-off");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
